>>> src/tlsf_pkg.sv
package tlsf_pkg;

  localparam int NUM_BLOCKS = 256;
  localparam int FL_CLASSES = 32;
  localparam int SL_CLASSES = 16;
  localparam int SIZE_BITS  = 31;

  localparam int HANDLE_W = $clog2(NUM_BLOCKS);
  localparam int FL_W     = $clog2(FL_CLASSES);
  localparam int SL_W     = $clog2(SL_CLASSES);
  localparam int IDX_W    = FL_W + SL_W;
  localparam int WORK_W   = 32;

  localparam logic [WORK_W-1:0] MIN_SIZE    = WORK_W'(64);
  localparam logic [WORK_W-1:0] ALIGN_BYTES = WORK_W'(8);
  localparam int                SMALL_SHIFT = $clog2(64 / SL_CLASSES);

  typedef enum logic [1:0] {
    OP_ALLOC = 2'd0,
    OP_FREE  = 2'd1,
    OP_ADD   = 2'd2
  } op_e;

  typedef enum logic [1:0] {
    STAT_OK     = 2'd0,
    STAT_NO_FIT = 2'd1,
    STAT_DUP    = 2'd2
  } status_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DISPATCH,
    ST_FR_WAIT,
    ST_AL_ROUND,
    ST_CLASS,
    ST_AL_SEARCH,
    ST_AL_SEARCH2,
    ST_AL_HREAD,
    ST_AL_HEAD,
    ST_AL_LINK,
    ST_PU_HREAD,
    ST_PU_WRITE,
    ST_RESP
  } state_e;

  typedef struct packed {
    logic                 link_vld;
    logic [HANDLE_W-1:0]  link;
    logic [SIZE_BITS-1:0] size;
  } blk_t;

  typedef struct packed {
    logic [FL_W-1:0] fl;
    logic [SL_W-1:0] sl;
  } class_t;

  function automatic logic [FL_W-1:0] top_bit(input logic [WORK_W-1:0] v);
    logic [FL_W-1:0] n;
    n = '0;
    for (int i = 1; i < WORK_W; i++) begin
      if (v[i]) n = FL_W'(i);
    end
    return n;
  endfunction

  function automatic logic [SL_W-1:0] low_bit_sl(input logic [SL_CLASSES-1:0] v);
    logic [SL_W-1:0] n;
    n = '0;
    for (int i = SL_CLASSES - 1; i >= 0; i--) begin
      if (v[i]) n = SL_W'(i);
    end
    return n;
  endfunction

  function automatic logic [FL_W-1:0] low_bit_fl(input logic [FL_CLASSES-1:0] v);
    logic [FL_W-1:0] n;
    n = '0;
    for (int i = FL_CLASSES - 1; i >= 0; i--) begin
      if (v[i]) n = FL_W'(i);
    end
    return n;
  endfunction

  // round up to the alignment and apply the minimum size
  function automatic logic [WORK_W-1:0] align_req(input logic [SIZE_BITS-1:0] r);
    logic [WORK_W-1:0] a;
    a = (WORK_W'(r) + (ALIGN_BYTES - WORK_W'(1))) & ~(ALIGN_BYTES - WORK_W'(1));
    if (a < MIN_SIZE) a = MIN_SIZE;
    return a;
  endfunction

  // bump a size past its class boundary so any block of that class fits
  function automatic logic [WORK_W-1:0] round_class(input logic [WORK_W-1:0] s);
    logic [FL_W-1:0] t;
    t = top_bit(s) - FL_W'(SL_W);
    return s + ((WORK_W'(1) << t) - WORK_W'(1));
  endfunction

  function automatic class_t classify(input logic [WORK_W-1:0] s);
    class_t          c;
    logic [FL_W-1:0] f;
    logic [WORK_W-1:0] sh;
    f  = top_bit(s);
    sh = s >> (f - FL_W'(SL_W));
    if (s < MIN_SIZE) begin
      c.fl = '0;
      c.sl = SL_W'(s >> SMALL_SHIFT);
    end else begin
      c.fl = f;
      c.sl = sh[SL_W-1:0];
    end
    return c;
  endfunction

endpackage

>>> src/tlsf_block_allocator_unit.sv
// Two-level segregated-fit allocator over numbered blocks.
// Input channel (in_valid_i/in_ready_o) carries one operation per item:
// allocate (request_size_i), free (block_handle_i) or add (block_handle_i
// with block_size_i). Output channel (out_valid_o/out_ready_i) returns one
// result item per operation: status, granted handle and size, and the
// class (first and second level) that the operation used.
// One item is processed at a time. A rejected handle or an unused op goes
// straight from dispatch to the response state; add, free and allocate pass
// through the class and list states. The next item
// is accepted in the cycle after the result is loaded. Processing time is set
// by the dependent read chain through the single-port head memory and the
// block memory (head, then next link), both with registered reads.
// A result waits in the output register; while the receiver stalls and a
// second result is ready, the block holds in its response state.
// Reset clears the bitmaps, the free flags and the handshakes. List heads,
// links and sizes are not cleared; heads and links are only used once a bitmap
// bit shows they were written, but a free reads a size with no such check.
module tlsf_block_allocator_unit (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  input  logic [1:0]                     op_i,
  input  logic [tlsf_pkg::SIZE_BITS-1:0] request_size_i,
  input  logic [tlsf_pkg::HANDLE_W-1:0]  block_handle_i,
  input  logic [tlsf_pkg::SIZE_BITS-1:0] block_size_i,
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output logic [1:0]                     status_o,
  output logic [tlsf_pkg::HANDLE_W-1:0]  grant_handle_o,
  output logic [tlsf_pkg::SIZE_BITS-1:0] grant_size_o,
  output logic [tlsf_pkg::FL_W-1:0]      class_fl_o,
  output logic [tlsf_pkg::SL_W-1:0]      class_sl_o
);
  import tlsf_pkg::*;

  state_e state_q, state_d;

  logic [FL_CLASSES-1:0] l1_q, l1_d;
  logic [SL_CLASSES-1:0] l2_q [FL_CLASSES];
  logic [SL_CLASSES-1:0] l2_d [FL_CLASSES];
  logic [NUM_BLOCKS-1:0] free_q, free_d;

  logic [1:0]           op_q;
  logic [SIZE_BITS-1:0] req_q, size_q;
  logic [HANDLE_W-1:0]  h_q, h_d;
  logic [WORK_W-1:0]    wsize_q, wsize_d;
  logic [FL_W-1:0]      fl_q, fl_d;
  logic [SL_W-1:0]      sl_q, sl_d;
  status_e              status_q, status_d;
  logic [HANDLE_W-1:0]  gh_q, gh_d;
  logic [SIZE_BITS-1:0] gs_q, gs_d;

  logic                 out_valid_q;
  status_e              out_status_q;
  logic [HANDLE_W-1:0]  out_gh_q;
  logic [SIZE_BITS-1:0] out_gs_q;
  logic [FL_W-1:0]      out_fl_q;
  logic [SL_W-1:0]      out_sl_q;

  // head memory, one entry per (fl, sl) list
  logic [HANDLE_W-1:0] head_mem [FL_CLASSES*SL_CLASSES];
  logic [IDX_W-1:0]    head_idx;
  logic                head_we;
  logic [HANDLE_W-1:0] head_wdata, head_rd_q;

  // block memory: next link and stored size per handle
  blk_t                blk_mem [NUM_BLOCKS];
  logic [HANDLE_W-1:0] blk_raddr;
  logic                blk_we;
  blk_t                blk_wdata, blk_rd_q;

  logic                  in_fire, out_free;
  logic [SL_CLASSES-1:0] l2_sel, sl_map, l2_rem;
  logic [FL_CLASSES-1:0] fl_map;
  logic [FL_CLASSES-1:0] l2_any;
  class_t                cls;

  assign in_ready_o = (state_q == ST_IDLE);
  assign in_fire    = in_valid_i && in_ready_o;
  assign out_free   = !out_valid_q || out_ready_i;

  assign head_idx = {fl_q, sl_q};
  assign cls      = classify(wsize_q);
  assign l2_sel   = l2_q[fl_q];
  assign sl_map   = l2_sel & ({SL_CLASSES{1'b1}} << sl_q);
  assign fl_map   = l1_q & ~((FL_CLASSES'(2) << fl_q) - FL_CLASSES'(1));
  assign l2_rem   = l2_sel & ~(SL_CLASSES'(1) << sl_q);

  always_ff @(posedge clk_i) begin
    if (head_we) head_mem[head_idx] <= head_wdata;
    head_rd_q <= head_mem[head_idx];
  end

  always_ff @(posedge clk_i) begin
    if (blk_we) blk_mem[h_q] <= blk_wdata;
    blk_rd_q <= blk_mem[blk_raddr];
  end

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: if (in_fire) state_d = ST_DISPATCH;
      ST_DISPATCH: begin
        unique case (op_q)
          OP_ALLOC: state_d = ST_AL_ROUND;
          OP_FREE:  state_d = free_q[h_q] ? ST_RESP : ST_FR_WAIT;
          OP_ADD:   state_d = free_q[h_q] ? ST_RESP : ST_CLASS;
          default:  state_d = ST_RESP;
        endcase
      end
      ST_FR_WAIT:  state_d = ST_CLASS;
      ST_AL_ROUND: state_d = ST_CLASS;
      ST_CLASS:    state_d = (op_q == OP_ALLOC) ? ST_AL_SEARCH : ST_PU_HREAD;
      ST_AL_SEARCH: begin
        if (sl_map != '0)      state_d = ST_AL_HREAD;
        else if (fl_map != '0) state_d = ST_AL_SEARCH2;
        else                   state_d = ST_RESP;
      end
      ST_AL_SEARCH2: state_d = ST_AL_HREAD;
      ST_AL_HREAD:   state_d = ST_AL_HEAD;
      ST_AL_HEAD:    state_d = ST_AL_LINK;
      ST_AL_LINK:    state_d = ST_RESP;
      ST_PU_HREAD:   state_d = ST_PU_WRITE;
      ST_PU_WRITE:   state_d = ST_RESP;
      ST_RESP:       if (out_free) state_d = ST_IDLE;
      default:       state_d = ST_IDLE;
    endcase
  end

  // datapath and memory control
  always_comb begin
    l1_d       = l1_q;
    l2_d       = l2_q;
    free_d     = free_q;
    h_d        = h_q;
    wsize_d    = wsize_q;
    fl_d       = fl_q;
    sl_d       = sl_q;
    status_d   = status_q;
    gh_d       = gh_q;
    gs_d       = gs_q;
    head_we    = 1'b0;
    head_wdata = h_q;
    blk_we     = 1'b0;
    blk_wdata  = '{link_vld: l2_sel[sl_q], link: head_rd_q,
                   size: wsize_q[SIZE_BITS-1:0]};
    blk_raddr  = h_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_fire) h_d = block_handle_i;
      end
      ST_DISPATCH: begin
        gh_d     = '0;
        gs_d     = '0;
        fl_d     = '0;
        sl_d     = '0;
        status_d = STAT_OK;
        unique case (op_q)
          OP_ALLOC: wsize_d = align_req(req_q);
          OP_FREE, OP_ADD: begin
            if (free_q[h_q]) status_d = STAT_DUP;
            // drop the two flag bits of an added size
            wsize_d = WORK_W'({size_q[SIZE_BITS-1:2], 2'b00});
          end
          default: ;
        endcase
      end
      ST_FR_WAIT:  wsize_d = WORK_W'(blk_rd_q.size);
      ST_AL_ROUND: wsize_d = round_class(wsize_q);
      ST_CLASS: begin
        fl_d = cls.fl;
        sl_d = cls.sl;
      end
      ST_AL_SEARCH: begin
        if (sl_map != '0)      sl_d = low_bit_sl(sl_map);
        else if (fl_map != '0) fl_d = low_bit_fl(fl_map);
        else                   status_d = STAT_NO_FIT;
      end
      ST_AL_SEARCH2: sl_d = low_bit_sl(l2_sel);
      ST_AL_HEAD: begin
        h_d       = head_rd_q;
        blk_raddr = head_rd_q;
      end
      ST_AL_LINK: begin
        // pop the head: advance to the next link or empty the list
        if (blk_rd_q.link_vld) begin
          head_we    = 1'b1;
          head_wdata = blk_rd_q.link;
        end else begin
          l2_d[fl_q] = l2_rem;
          if (l2_rem == '0) l1_d[fl_q] = 1'b0;
        end
        free_d[h_q] = 1'b0;
        status_d    = STAT_OK;
        gh_d        = h_q;
        gs_d        = blk_rd_q.size;
      end
      ST_PU_WRITE: begin
        blk_we           = 1'b1;
        head_we          = 1'b1;
        l1_d[fl_q]       = 1'b1;
        l2_d[fl_q][sl_q] = 1'b1;
        free_d[h_q]      = 1'b1;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      l1_q        <= '0;
      free_q      <= '0;
      out_valid_q <= 1'b0;
      for (int i = 0; i < FL_CLASSES; i++) l2_q[i] <= '0;
    end else begin
      state_q <= state_d;
      l1_q    <= l1_d;
      l2_q    <= l2_d;
      free_q  <= free_d;
      if (state_q == ST_RESP && out_free) out_valid_q <= 1'b1;
      else if (out_ready_i)               out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      op_q   <= op_i;
      req_q  <= request_size_i;
      size_q <= block_size_i;
    end
    h_q      <= h_d;
    wsize_q  <= wsize_d;
    fl_q     <= fl_d;
    sl_q     <= sl_d;
    status_q <= status_d;
    gh_q     <= gh_d;
    gs_q     <= gs_d;
    if (state_q == ST_RESP && out_free) begin
      out_status_q <= status_q;
      out_gh_q     <= gh_q;
      out_gs_q     <= gs_q;
      out_fl_q     <= fl_q;
      out_sl_q     <= sl_q;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign status_o       = out_status_q;
  assign grant_handle_o = out_gh_q;
  assign grant_size_o   = out_gs_q;
  assign class_fl_o     = out_fl_q;
  assign class_sl_o     = out_sl_q;

  always_comb begin
    for (int i = 0; i < FL_CLASSES; i++) l2_any[i] = |l2_q[i];
  end

  a_l1_tracks_l2: assert property (@(posedge clk_i) disable iff (!rst_ni)
    l1_q == l2_any)
    else $error("first-level bitmap out of step with second-level bitmaps");

  a_one_at_a_time: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire |=> !in_ready_o)
    else $error("item accepted while another is in progress");

  a_pop_free_block: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_AL_LINK |-> free_q[h_q])
    else $error("list head is not a free block");

  a_push_busy_block: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_PU_WRITE |-> !free_q[h_q])
    else $error("pushing a block that is already free");

endmodule

>>> test/tb_top.sv
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import tlsf_pkg::*;

  localparam int RANDOM_ITEMS   = 1400;
  localparam int QUIET_ITEMS    = 150;
  localparam int PAUSE_AT       = 700;
  localparam int HOLD_AFTER     = 400;
  localparam int LONG_HOLD      = 150;
  localparam int WATCHDOG_LIMIT = 3000;
  localparam int DRAIN_CYCLES   = 16;
  localparam int GRAIN_SHIFT    = 2;

  localparam logic [1:0]           OP_UNUSED = 2'd3;
  localparam logic [SIZE_BITS-1:0] SIZE_TOP  = '1;
  localparam logic [SIZE_BITS-1:0] FLAG_MASK = SIZE_BITS'(3);

  typedef struct packed {
    status_e              status;
    logic [HANDLE_W-1:0]  handle;
    logic [SIZE_BITS-1:0] size;
    logic [FL_W-1:0]      fl;
    logic [SL_W-1:0]      sl;
  } response_t;

  typedef struct {
    logic [1:0]           op;
    logic [SIZE_BITS-1:0] req;
    logic [HANDLE_W-1:0]  handle;
    logic [SIZE_BITS-1:0] bsize;
    bit                   known;
    response_t            want;
  } row_t;

  logic                 clk_i;
  logic                 rst_ni         = 1'b0;
  logic                 in_valid_i     = 1'b0;
  logic                 in_ready_o;
  logic [1:0]           op_i           = '0;
  logic [SIZE_BITS-1:0] request_size_i = '0;
  logic [HANDLE_W-1:0]  block_handle_i = '0;
  logic [SIZE_BITS-1:0] block_size_i   = '0;
  logic                 out_valid_o;
  logic                 out_ready_i    = 1'b0;
  logic [1:0]           status_o;
  logic [HANDLE_W-1:0]  grant_handle_o;
  logic [SIZE_BITS-1:0] grant_size_o;
  logic [FL_W-1:0]      class_fl_o;
  logic [SL_W-1:0]      class_sl_o;

  // shadow of the allocator: bitmaps, list heads, links, sizes, free flags
  logic [FL_CLASSES-1:0] fl_map = '0;
  logic [SL_CLASSES-1:0] sl_map [FL_CLASSES] = '{default: '0};
  logic [HANDLE_W-1:0]   head_of [FL_CLASSES*SL_CLASSES];
  bit                    link_ok [NUM_BLOCKS];
  logic [HANDLE_W-1:0]   link_to [NUM_BLOCKS];
  logic [SIZE_BITS-1:0]  size_of [NUM_BLOCKS];
  bit                    is_free [NUM_BLOCKS];
  bit                    ever_added [NUM_BLOCKS];

  response_t pending_responses [$];
  row_t      script [$];
  int        failures    = 0;
  int        items_taken = 0;
  int        idle_cycles = 0;
  bit        quiet       = 1'b0;
  bit        held_long   = 1'b0;

  tlsf_block_allocator_unit dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .op_i           (op_i),
    .request_size_i (request_size_i),
    .block_handle_i (block_handle_i),
    .block_size_i   (block_size_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .status_o       (status_o),
    .grant_handle_o (grant_handle_o),
    .grant_size_o   (grant_size_o),
    .class_fl_o     (class_fl_o),
    .class_sl_o     (class_sl_o)
  );

  function automatic int msb_pos(input logic [31:0] v);
    int n;
    n = 0;
    for (int i = 0; i < 32; i++) if (v[i]) n = i;
    return n;
  endfunction

  function automatic int lsb_pos(input logic [31:0] v);
    int n;
    n = 0;
    for (int i = 31; i >= 0; i--) if (v[i]) n = i;
    return n;
  endfunction

  function automatic class_t size_class(input logic [31:0] s);
    class_t      c;
    int          f;
    logic [31:0] q;
    if (s < MIN_SIZE) begin
      c.fl = '0;
      q    = s >> GRAIN_SHIFT;
    end else begin
      f    = msb_pos(s);
      c.fl = FL_W'(f);
      q    = (s >> (f - SL_W)) - 32'(SL_CLASSES);
    end
    if (q > SL_CLASSES - 1) q = SL_CLASSES - 1;
    c.sl = SL_W'(q);
    return c;
  endfunction

  function automatic response_t push_block(input logic [HANDLE_W-1:0] h);
    class_t    c;
    int        idx;
    response_t r;
    c   = size_class({1'b0, size_of[h]});
    idx = int'(c.fl) * SL_CLASSES + int'(c.sl);
    link_ok[h] = sl_map[c.fl][c.sl];
    if (link_ok[h]) link_to[h] = head_of[idx];
    head_of[idx]         = h;
    fl_map[c.fl]         = 1'b1;
    sl_map[c.fl][c.sl]   = 1'b1;
    is_free[h]           = 1'b1;
    r        = '0;
    r.status = STAT_OK;
    r.fl     = c.fl;
    r.sl     = c.sl;
    return r;
  endfunction

  function automatic response_t grant_block(input logic [SIZE_BITS-1:0] req);
    logic [31:0]           s;
    logic [31:0]           upper;
    logic [SL_CLASSES-1:0] cand;
    logic [HANDLE_W-1:0]   h;
    class_t                c;
    int                    fl;
    int                    sl;
    int                    idx;
    response_t             r;
    s = ({1'b0, req} + (ALIGN_BYTES - 32'd1)) & ~(ALIGN_BYTES - 32'd1);
    if (s < MIN_SIZE) s = MIN_SIZE;
    // round up so that any block in the resulting class is large enough
    s = s + ((32'd1 << (msb_pos(s) - SL_W)) - 32'd1);
    c = size_class(s);
    r        = '0;
    r.status = STAT_NO_FIT;
    r.fl     = c.fl;
    r.sl     = c.sl;
    fl   = int'(c.fl);
    sl   = int'(c.sl);
    cand = sl_map[fl] & ({SL_CLASSES{1'b1}} << sl);
    if (cand == '0) begin
      upper = (fl == FL_CLASSES - 1) ? '0 : 32'(fl_map & ({FL_CLASSES{1'b1}} << (fl + 1)));
      if (upper == '0) return r;
      fl   = lsb_pos(upper);
      cand = sl_map[fl];
    end
    sl  = lsb_pos(32'(cand));
    idx = fl * SL_CLASSES + sl;
    h   = head_of[idx];
    if (link_ok[h]) begin
      head_of[idx] = link_to[h];
    end else begin
      sl_map[fl][sl] = 1'b0;
      if (sl_map[fl] == '0) fl_map[fl] = 1'b0;
    end
    is_free[h] = 1'b0;
    r.status   = STAT_OK;
    r.handle   = h;
    r.size     = size_of[h];
    r.fl       = FL_W'(fl);
    r.sl       = SL_W'(sl);
    return r;
  endfunction

  function automatic response_t allocator_step(input logic [1:0] op,
                                               input logic [SIZE_BITS-1:0] req,
                                               input logic [HANDLE_W-1:0] h,
                                               input logic [SIZE_BITS-1:0] bs);
    response_t r;
    r        = '0;
    r.status = STAT_OK;
    case (op)
      OP_ALLOC: r = grant_block(req);
      OP_FREE, OP_ADD: begin
        if (is_free[h]) begin
          r.status = STAT_DUP;
        end else begin
          if (op == OP_ADD) begin
            size_of[h]    = bs & ~FLAG_MASK;
            ever_added[h] = 1'b1;
          end
          r = push_block(h);
        end
      end
      default: ;
    endcase
    return r;
  endfunction

  function automatic row_t make_row(input logic [1:0] op, input logic [SIZE_BITS-1:0] req,
                                    input logic [HANDLE_W-1:0] h,
                                    input logic [SIZE_BITS-1:0] bs, input bit known,
                                    input status_e st, input logic [HANDLE_W-1:0] gh,
                                    input logic [SIZE_BITS-1:0] gs,
                                    input logic [FL_W-1:0] fl, input logic [SL_W-1:0] sl);
    row_t w;
    w.op          = op;
    w.req         = req;
    w.handle      = h;
    w.bsize       = bs;
    w.known       = known;
    w.want.status = st;
    w.want.handle = gh;
    w.want.size   = gs;
    w.want.fl     = fl;
    w.want.sl     = sl;
    return w;
  endfunction

  // mostly small sizes so that allocations find blocks; now and then any size
  function automatic logic [SIZE_BITS-1:0] rand_size();
    int k;
    if ($urandom_range(0, 24) == 0) return SIZE_BITS'($urandom());
    k = ($urandom_range(0, 3) == 0) ? $urandom_range(1, SIZE_BITS - 1) : $urandom_range(5, 13);
    return SIZE_BITS'($urandom_range(0, (1 << k) - 1));
  endfunction

  function automatic int pick_handle(input bit need_added, input bit need_busy);
    int start;
    int h;
    start = $urandom_range(0, NUM_BLOCKS - 1);
    for (int k = 0; k < NUM_BLOCKS; k++) begin
      h = (start + k) % NUM_BLOCKS;
      if ((!need_added || ever_added[h]) && (!need_busy || !is_free[h])) return h;
    end
    return -1;
  endfunction

  function automatic void check_field(input string name, input logic [31:0] want,
                                      input logic [31:0] got);
    if (got !== want) begin
      $display("%0t: %s expected %0d got %0d", $time, name, want, got);
      failures++;
    end
  endfunction

  task automatic offer(input logic [1:0] op, input logic [SIZE_BITS-1:0] req,
                       input logic [HANDLE_W-1:0] h, input logic [SIZE_BITS-1:0] bs,
                       input bit known, input response_t want);
    response_t got;
    in_valid_i     <= 1'b1;
    op_i           <= op;
    request_size_i <= req;
    block_handle_i <= h;
    block_size_i   <= bs;
    do @(posedge clk_i); while (!in_ready_o);
    got = allocator_step(op, req, h, bs);
    pending_responses.push_back(known ? want : got);
    items_taken++;
  endtask

  task automatic rest(input int cycles);
    in_valid_i <= 1'b0;
    repeat (cycles) @(posedge clk_i);
  endtask

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  initial begin
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
  end

  // receiver: short random stalls, one long hold-off, none near the end
  initial begin
    wait (rst_ni);
    @(posedge clk_i);
    forever begin
      if (!held_long && items_taken >= HOLD_AFTER) begin
        held_long = 1'b1;
        out_ready_i <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk_i);
      end else if (!quiet && $urandom_range(0, 4) == 0) begin
        out_ready_i <= 1'b0;
        repeat ($urandom_range(1, 4)) @(posedge clk_i);
      end else begin
        out_ready_i <= 1'b1;
        @(posedge clk_i);
      end
    end
  end

  always @(posedge clk_i) begin : result_check
    response_t want;
    if (rst_ni) begin
      if (out_valid_o && out_ready_i) begin
        if (pending_responses.size() == 0) begin
          $display("%0t: result with nothing pending, status %0d handle %0d", $time,
                   status_o, grant_handle_o);
          failures++;
        end else begin
          want = pending_responses.pop_front();
          check_field("status", want.status, status_o);
          check_field("grant_handle", want.handle, grant_handle_o);
          check_field("grant_size", want.size, grant_size_o);
          check_field("class_fl", want.fl, class_fl_o);
          check_field("class_sl", want.sl, class_sl_o);
        end
      end
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("tlsf_block_allocator_unit: mismatch");
        $finish;
      end
    end
  end

  initial begin : stimulus
    int                   n;
    int                   pick;
    int                   roll;
    bit                   paused;
    logic [1:0]           op;
    logic [SIZE_BITS-1:0] req;
    logic [HANDLE_W-1:0]  h;
    logic [SIZE_BITS-1:0] bs;

    n      = 0;
    paused = 1'b0;

    // empty allocator, extremes, flag bits, duplicates, LIFO order, replacement
    script.push_back(make_row(OP_ALLOC, 0, 0, 0, 1, STAT_NO_FIT, 0, 0, 6, 0));
    script.push_back(make_row(OP_ALLOC, SIZE_TOP, 0, 0, 1, STAT_NO_FIT, 0, 0, 31, 0));
    script.push_back(make_row(OP_UNUSED, SIZE_TOP, 255, SIZE_TOP, 1, STAT_OK, 0, 0, 0, 0));
    script.push_back(make_row(OP_ADD, 0, 0, 64, 1, STAT_OK, 0, 0, 6, 0));
    script.push_back(make_row(OP_ADD, 0, 0, 100, 1, STAT_DUP, 0, 0, 0, 0));
    script.push_back(make_row(OP_FREE, 0, 0, 0, 1, STAT_DUP, 0, 0, 0, 0));
    script.push_back(make_row(OP_ADD, 0, 255, SIZE_TOP, 1, STAT_OK, 0, 0, 30, 15));
    script.push_back(make_row(OP_ADD, 0, 1, 3, 1, STAT_OK, 0, 0, 0, 0));
    script.push_back(make_row(OP_ADD, 0, 2, 63, 1, STAT_OK, 0, 0, 0, 15));
    script.push_back(make_row(OP_ADD, 0, 3, 0, 1, STAT_OK, 0, 0, 0, 0));
    script.push_back(make_row(OP_ALLOC, 1, 0, 0, 1, STAT_OK, 0, 64, 6, 0));
    script.push_back(make_row(OP_ALLOC, 64, 0, 0, 1, STAT_OK, 255, 31'd2147483644, 30, 15));
    script.push_back(make_row(OP_ALLOC, 8, 0, 0, 1, STAT_NO_FIT, 0, 0, 6, 0));
    script.push_back(make_row(OP_FREE, 0, 0, 0, 1, STAT_OK, 0, 0, 6, 0));
    script.push_back(make_row(OP_ADD, 0, 255, 1000, 0, STAT_OK, 0, 0, 0, 0));
    script.push_back(make_row(OP_ADD, 0, 10, 64, 0, STAT_OK, 0, 0, 0, 0));
    script.push_back(make_row(OP_ADD, 0, 11, 64, 0, STAT_OK, 0, 0, 0, 0));
    script.push_back(make_row(OP_ALLOC, 64, 0, 0, 0, STAT_OK, 0, 0, 0, 0));
    script.push_back(make_row(OP_ALLOC, 64, 0, 0, 0, STAT_OK, 0, 0, 0, 0));
    script.push_back(make_row(OP_ALLOC, 64, 0, 0, 0, STAT_OK, 0, 0, 0, 0));
    script.push_back(make_row(OP_ALLOC, 65, 0, 0, 0, STAT_OK, 0, 0, 0, 0));
    script.push_back(make_row(OP_FREE, 0, 255, 0, 0, STAT_OK, 0, 0, 0, 0));
    script.push_back(make_row(OP_ADD, 0, 128, 31'h4000_0000, 0, STAT_OK, 0, 0, 0, 0));
    script.push_back(make_row(OP_ALLOC, 31'h4000_0000, 0, 0, 0, STAT_OK, 0, 0, 0, 0));
    script.push_back(make_row(OP_FREE, 0, 1, 0, 1, STAT_DUP, 0, 0, 0, 0));

    wait (rst_ni);
    @(posedge clk_i);

    foreach (script[i]) begin
      if ($urandom_range(0, 5) == 0) rest($urandom_range(1, 4));
      offer(script[i].op, script[i].req, script[i].handle, script[i].bsize,
            script[i].known, script[i].want);
    end

    while (n < RANDOM_ITEMS) begin
      quiet = (n >= RANDOM_ITEMS - QUIET_ITEMS);
      if (n == PAUSE_AT && !paused) begin
        // hold the input until the allocator has drained
        paused = 1'b1;
        in_valid_i <= 1'b0;
        do @(posedge clk_i); while (pending_responses.size() != 0);
      end else if (!quiet && $urandom_range(0, 5) == 0) begin
        rest($urandom_range(1, 4));
      end
      req  = rand_size();
      bs   = rand_size();
      h    = HANDLE_W'($urandom());
      roll = $urandom_range(0, 99);
      if (roll < 36) begin
        op = OP_ADD;
        if ($urandom_range(0, 4) != 0) begin
          pick = pick_handle(1'b0, 1'b1);
          if (pick >= 0) h = HANDLE_W'(pick);
        end
      end else if (roll < 60) begin
        // free only blocks that were added at some point; some are already free
        op   = OP_FREE;
        pick = pick_handle(1'b1, $urandom_range(0, 7) != 0);
        if (pick < 0) op = OP_ADD;
        else h = HANDLE_W'(pick);
      end else if (roll < 96) begin
        op = OP_ALLOC;
      end else begin
        op = OP_UNUSED;
      end
      offer(op, req, h, bs, 1'b0, '0);
      if (op != OP_UNUSED) n++;
    end

    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (pending_responses.size() != 0);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (failures == 0) $display("tlsf_block_allocator_unit: match");
    else $display("tlsf_block_allocator_unit: mismatch");
    $finish;
  end

endmodule

>>> sim.f
src/tlsf_pkg.sv
src/tlsf_block_allocator_unit.sv
test/tb_top.sv
